>>> rtl/drs_pkg.sv
// drs_pkg: shared types, constants and config register indexes
// for the disparity reprojection error statistics block; no dependencies
package drs_pkg;

	localparam int MaxWidthDef  = 4096;
	localparam int MaxHeightDef = 4096;

	localparam logic [2:0] REG_OFFSET_X = 3'd0;
	localparam logic [2:0] REG_OFFSET_Y = 3'd1;
	localparam logic [2:0] REG_FOCAL    = 3'd2;
	localparam logic [2:0] REG_W_GAIN   = 3'd3;
	localparam logic [2:0] REG_W_OFFSET = 3'd4;
	localparam logic [2:0] REG_WIDTH    = 3'd5;

	localparam logic [24:0] CountMax = 25'h1FFFFFF;
	localparam logic [56:0] SumMax   = {57{1'b1}};

	// classified pixel handed from front to back
	typedef struct packed {
		logic               ok;
		logic               last;
		logic signed [48:0] nx;
		logic signed [48:0] ny;
		logic signed [48:0] nz;
		logic signed [52:0] wq;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
	} job_t;

endpackage

>>> rtl/disparity_reprojection_error_stats_core.sv
// disparity_reprojection_error_stats_core: top level of the reprojection block
// depends on drs_pkg, drs_front, drs_queue, drs_back
//
// Pixels enter a one-stage front that checks mask, row and shifted column and
// forms the numerators and W; a four-entry queue feeds a back-end sequencer that
// runs three 81-bit restoring divisions (X, Y, Z) through one shared divider
// and one bit-serial square root for the error; the last pixel of a frame adds,
// when the count is nonzero, two more divisions and a root for mean and RMSE,
// then clears the statistics. Results leave through a registered output with
// valid/ready; each pixel gives one transfer and the last pixel a second,
// summary transfer.
module disparity_reprojection_error_stats_core #(
	parameter int MAX_WIDTH  = drs_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = drs_pkg::MaxHeightDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [11:0]        row_index,
	input  logic [11:0]        col_index,
	input  logic signed [15:0] disparity,
	input  logic               mask_valid,
	input  logic signed [31:0] truth_x,
	input  logic signed [31:0] truth_y,
	input  logic signed [31:0] truth_z,
	input  logic               last_pixel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_summary,
	output logic               point_valid,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic [31:0]        error_distance,
	output logic [24:0]        point_count,
	output logic [31:0]        error_min,
	output logic [31:0]        error_max,
	output logic [31:0]        error_mean,
	output logic [31:0]        error_rmse,
	output logic               last_result
);
	// configuration registers
	logic signed [16:0] offset_x_q, offset_y_q;
	logic [19:0]        focal_q;
	logic signed [31:0] w_gain_q, w_offset_q;
	logic [12:0]        width_q;

	// front to queue, queue to back
	logic          fj_valid, fj_ready, bj_valid, bj_ready;
	drs_pkg::job_t fj, bj;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0; offset_y_q <= '0; focal_q <= '0;
			w_gain_q <= '0; w_offset_q <= '0; width_q <= 13'd4096;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				drs_pkg::REG_OFFSET_X: offset_x_q <= cfg_data[16:0];
				drs_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data[16:0];
				drs_pkg::REG_FOCAL:    focal_q    <= cfg_data[19:0];
				drs_pkg::REG_W_GAIN:   w_gain_q   <= cfg_data;
				drs_pkg::REG_W_OFFSET: w_offset_q <= cfg_data;
				drs_pkg::REG_WIDTH:    width_q    <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	drs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .row_index, .col_index, .disparity,
		.mask_valid, .truth_x, .truth_y, .truth_z, .last_pixel,
		.offset_x(offset_x_q), .offset_y(offset_y_q), .focal_length(focal_q),
		.w_gain(w_gain_q), .w_offset(w_offset_q), .image_width(width_q),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	drs_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
	);

	drs_back u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.out_valid, .out_ready, .is_summary, .point_valid, .point_x, .point_y,
		.point_z, .error_distance, .point_count, .error_min, .error_max,
		.error_mean, .error_rmse, .last_result
	);
endmodule

>>> rtl/drs_front.sv
// drs_front: accepts pixels, runs range checks and forms numerators and W
// depends on drs_pkg
module drs_front #(
	parameter int MAX_WIDTH  = drs_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = drs_pkg::MaxHeightDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [11:0]         row_index,
	input  logic [11:0]         col_index,
	input  logic signed [15:0]  disparity,
	input  logic                mask_valid,
	input  logic signed [31:0]  truth_x,
	input  logic signed [31:0]  truth_y,
	input  logic signed [31:0]  truth_z,
	input  logic                last_pixel,
	input  logic signed [16:0]  offset_x,
	input  logic signed [16:0]  offset_y,
	input  logic [19:0]         focal_length,
	input  logic signed [31:0]  w_gain,
	input  logic signed [31:0]  w_offset,
	input  logic [12:0]         image_width,
	output logic                job_valid,
	input  logic                job_ready,
	output drs_pkg::job_t       job
);
	localparam logic [13:0] MaxW = 14'(MAX_WIDTH);
	localparam logic [13:0] MaxH = 14'(MAX_HEIGHT);

	logic               v_s1;
	drs_pkg::job_t      j_s1;
	logic signed [47:0] prod;
	logic [13:0]        wb;
	logic signed [18:0] shifted;
	logic               ok;

	assign in_ready = !v_s1 || job_ready;
	assign prod     = w_gain * disparity;
	assign wb       = ({1'b0, image_width} > MaxW) ? MaxW : {1'b0, image_width};
	assign shifted  = $signed({3'b0, col_index, 4'b0}) + 19'(disparity);
	assign ok = mask_valid && ({2'b0, row_index} < MaxH) && !shifted[18]
		&& ($signed(shifted) < $signed({1'b0, wb, 4'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			j_s1.ok   <= ok;
			j_s1.last <= last_pixel;
			j_s1.nx   <= 49'($signed({1'b0, row_index, 4'b0}) + 18'(offset_x));
			j_s1.ny   <= 49'($signed({1'b0, col_index, 4'b0}) + 18'(offset_y));
			j_s1.nz   <= $signed({29'b0, focal_length});
			j_s1.wq   <= 53'(prod) + 53'($signed({w_offset, 4'b0}));
			j_s1.tx   <= truth_x;
			j_s1.ty   <= truth_y;
			j_s1.tz   <= truth_z;
		end
	end

	assign job_valid = v_s1;
	assign job       = j_s1;
endmodule

>>> rtl/drs_queue.sv
// drs_queue: small fifo decoupling the front from the back
// depends on drs_pkg
module drs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  drs_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output drs_pkg::job_t rd_data
);
	drs_pkg::job_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end
endmodule

>>> rtl/drs_divider.sv
// drs_divider: restoring unsigned divider, one quotient bit per cycle
// no dependencies
module drs_divider #(
	parameter int NW = 81,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] n_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {r_q[DW-1:0], q_q[NW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign busy  = n_q != '0;
	assign quot  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (start) begin
			n_q <= CW'(NW);
		end else if (busy) begin
			n_q <= n_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num; r_q <= '0; d_q <= den;
		end else if (busy) begin
			if (!diff[DW]) begin
				r_q <= diff;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/drs_sqrt.sv
// drs_sqrt: bit-serial integer square root of a 64-bit value
// no dependencies
module drs_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);
	logic [63:0] v_q;
	logic [33:0] r_q;
	logic [31:0] q_q;
	logic [5:0]  n_q;
	logic [33:0] trial;
	logic [33:0] diff;

	assign trial = {r_q[31:0], v_q[63:62]};
	assign diff  = trial - {q_q, 2'b01};
	assign busy  = n_q != '0;
	assign root  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (start) begin
			n_q <= 6'd32;
		end else if (busy) begin
			n_q <= n_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand; r_q <= '0; q_q <= '0;
		end else if (busy) begin
			v_q <= {v_q[61:0], 2'b0};
			if (!diff[33]) begin
				r_q <= diff;
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/drs_back.sv
// drs_back: sequencer that divides, measures the error, updates statistics
// and emits results; depends on drs_pkg, drs_divider, drs_sqrt
module drs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  drs_pkg::job_t       job,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                is_summary,
	output logic                point_valid,
	output logic signed [31:0]  point_x,
	output logic signed [31:0]  point_y,
	output logic signed [31:0]  point_z,
	output logic [31:0]         error_distance,
	output logic [24:0]         point_count,
	output logic [31:0]         error_min,
	output logic [31:0]         error_max,
	output logic [31:0]         error_mean,
	output logic [31:0]         error_rmse,
	output logic                last_result
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_DWT  = 4'd2;
	localparam logic [3:0] ST_SQ   = 4'd3;
	localparam logic [3:0] ST_SUM  = 4'd4;
	localparam logic [3:0] ST_ERR  = 4'd5;
	localparam logic [3:0] ST_EWT  = 4'd6;
	localparam logic [3:0] ST_ACC  = 4'd7;
	localparam logic [3:0] ST_PIX  = 4'd8;
	localparam logic [3:0] ST_MD   = 4'd9;
	localparam logic [3:0] ST_MWT  = 4'd10;
	localparam logic [3:0] ST_RD   = 4'd11;
	localparam logic [3:0] ST_RWT  = 4'd12;
	localparam logic [3:0] ST_RS   = 4'd13;
	localparam logic [3:0] ST_RSW  = 4'd14;
	localparam logic [3:0] ST_SUMO = 4'd15;

	logic [3:0]  st_q;
	logic [1:0]  k_q;
	drs_pkg::job_t j_q;
	logic signed [81:0] p_q [3];
	logic [32:0] a_q [3];
	logic [65:0] sq_q [3];
	logic [63:0] ss_q;
	logic        ov_q;
	logic [31:0] err_q;
	logic [24:0] cnt_q;
	logic [31:0] min_q, max_q;
	logic [56:0] esum_q;
	logic [63:0] sqsum_q;
	logic [31:0] mean_q;
	logic        ov_valid_q;

	logic        div_start, div_busy;
	logic [80:0] div_num, div_quot;
	logic [63:0] div_den;
	logic        sq_start, sq_busy;
	logic [63:0] sq_in;
	logic [31:0] sq_root;

	logic signed [48:0] numk;
	logic        wneg, nneg;
	logic [52:0] wabs;
	logic [48:0] nabs;
	logic signed [81:0] pk;
	logic signed [81:0] dk;
	logic [64:0] add1;
	logic [63:0] esq;
	logic [64:0] sqadd;
	logic [57:0] eadd;
	logic        out_load;

	assign wneg = j_q.wq[52];
	assign wabs = wneg ? 53'(-j_q.wq) : j_q.wq;
	always_comb begin
		unique case (k_q)
			2'd0:    numk = j_q.nx;
			2'd1:    numk = j_q.ny;
			default: numk = j_q.nz;
		endcase
	end
	assign nneg = numk[48];
	assign nabs = nneg ? 49'(-numk) : numk;

	assign div_start = (st_q == ST_DIV) || (st_q == ST_MD) || (st_q == ST_RD);
	always_comb begin
		div_num = {nabs, 32'b0};
		div_den = {11'b0, wabs};
		if (st_q == ST_MD) begin
			div_num = {24'b0, esum_q};
			div_den = {39'b0, cnt_q};
		end else if (st_q == ST_RD) begin
			div_num = {17'b0, sqsum_q};
			div_den = {39'b0, cnt_q};
		end
	end

	assign pk = (nneg ^ wneg) ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
	always_comb begin
		unique case (k_q)
			2'd0:    dk = 82'(j_q.tx) - pk;
			2'd1:    dk = 82'(j_q.ty) - pk;
			default: dk = 82'(j_q.tz) - pk;
		endcase
	end

	assign add1  = {1'b0, ss_q} + {1'b0, sq_q[k_q][63:0]};
	assign esq   = err_q * err_q;
	assign sqadd = {1'b0, sqsum_q} + {1'b0, esq};
	assign eadd  = {1'b0, esum_q} + {26'b0, err_q};

	assign sq_start = (st_q == ST_ERR) || (st_q == ST_RS);
	assign sq_in    = (st_q == ST_RS) ? div_quot[63:0] : ss_q;
	assign job_ready = st_q == ST_IDLE && !out_valid;
	// a new result is loaded into the output register this cycle
	assign out_load = ((st_q == ST_PIX) || (st_q == ST_SUMO)) && (!out_valid || out_ready);

	drs_divider #(.NW(81), .DW(64)) u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quot(div_quot)
	);
	drs_sqrt u_sqrt (
		.clk, .arst_n, .start(sq_start), .radicand(sq_in), .busy(sq_busy), .root(sq_root)
	);

	function automatic logic [31:0] sat32(input logic signed [81:0] v);
		logic [31:0] r;
		if (v > 82'sd2147483647) r = 32'h7FFFFFFF;
		else if (v < -82'sd2147483648) r = 32'h80000000;
		else r = v[31:0];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
			cnt_q <= '0; min_q <= '1; max_q <= '0; esum_q <= '0; sqsum_q <= '0;
			k_q <= '0;
		end else begin
			if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (job_valid && job_ready) begin
					j_q <= job;
					k_q <= 2'd0;
					ss_q <= '0; ov_q <= 1'b0;
					st_q <= (job.ok && job.wq != '0) ? ST_DIV : ST_PIX;
					ov_valid_q <= job.ok && job.wq != '0;
				end
				ST_DIV: st_q <= ST_DWT;
				ST_DWT: if (!div_busy) begin
					p_q[k_q] <= pk;
					a_q[k_q] <= dk[81] ? 33'(-dk) : 33'(dk);
					if ((dk[81] ? -dk : dk) >= 82'sh0FFFFFFFF) ov_q <= 1'b1;
					st_q <= ST_SQ;
				end
				ST_SQ: begin
					sq_q[k_q] <= a_q[k_q] * a_q[k_q];
					st_q <= ST_SUM;
				end
				ST_SUM: begin
					if (add1[64] || sq_q[k_q][65:64] != 2'b0) ov_q <= 1'b1;
					ss_q <= add1[63:0];
					if (k_q == 2'd2) begin
						st_q <= ST_ERR;
					end else begin
						k_q <= k_q + 2'd1;
						st_q <= ST_DIV;
					end
				end
				ST_ERR: st_q <= ST_EWT;
				ST_EWT: if (!sq_busy) begin
					err_q <= ov_q ? 32'hFFFFFFFF : sq_root;
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					if (cnt_q != drs_pkg::CountMax) begin
						cnt_q <= cnt_q + 25'd1;
						if (err_q < min_q) min_q <= err_q;
						if (err_q > max_q) max_q <= err_q;
						esum_q <= eadd[57] ? drs_pkg::SumMax : (eadd[56:0]);
						sqsum_q <= sqadd[64] ? '1 : sqadd[63:0];
					end
					st_q <= ST_PIX;
				end
				ST_PIX: if (!out_valid || out_ready) begin
					out_valid      <= 1'b1;
					is_summary     <= 1'b0;
					point_valid    <= ov_valid_q;
					point_x        <= ov_valid_q ? sat32(p_q[0]) : '0;
					point_y        <= ov_valid_q ? sat32(p_q[1]) : '0;
					point_z        <= ov_valid_q ? sat32(p_q[2]) : '0;
					error_distance <= ov_valid_q ? err_q : '0;
					point_count    <= cnt_q;
					error_min      <= cnt_q != '0 ? min_q : '0;
					error_max      <= cnt_q != '0 ? max_q : '0;
					error_mean     <= '0;
					error_rmse     <= '0;
					last_result    <= !j_q.last;
					st_q <= j_q.last ? (cnt_q != '0 ? ST_MD : ST_SUMO) : ST_IDLE;
					mean_q <= '0;
				end
				ST_MD: st_q <= ST_MWT;
				ST_MWT: if (!div_busy) begin
					mean_q <= div_quot[31:0];
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_RWT;
				ST_RWT: if (!div_busy) st_q <= ST_RS;
				ST_RS: st_q <= ST_RSW;
				ST_RSW: if (!sq_busy) begin
					err_q <= sq_root;
					st_q <= ST_SUMO;
				end
				ST_SUMO: if (!out_valid || out_ready) begin
					out_valid      <= 1'b1;
					is_summary     <= 1'b1;
					point_valid    <= 1'b0;
					point_x        <= '0;
					point_y        <= '0;
					point_z        <= '0;
					error_distance <= '0;
					point_count    <= cnt_q;
					error_min      <= cnt_q != '0 ? min_q : '0;
					error_max      <= cnt_q != '0 ? max_q : '0;
					error_mean     <= cnt_q != '0 ? mean_q : '0;
					error_rmse     <= cnt_q != '0 ? err_q : '0;
					last_result    <= 1'b1;
					cnt_q <= '0; min_q <= '1; max_q <= '0; esum_q <= '0; sqsum_q <= '0;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> st_q == ST_IDLE) else $error("job taken while busy");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_ACC && cnt_q == drs_pkg::CountMax |=> cnt_q == drs_pkg::CountMax)
		else $error("count wrapped");
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_summary |-> last_result) else $error("summary not last");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SUMO && (!out_valid || out_ready) |=> cnt_q == '0)
		else $error("stats not cleared");
endmodule

>>> verif/disparity_reprojection_error_stats_core_test.sv
// disparity_reprojection_error_stats_core_test: self-checking bench for the reprojection
// and error statistics core; depends on drs_pkg and disparity_reprojection_error_stats_core
`timescale 1ns / 100ps

module disparity_reprojection_error_stats_core_test;

	// one pixel as it crosses the input transfer
	typedef struct {
		logic [11:0]        row;
		logic [11:0]        col;
		logic signed [15:0] disp;
		logic               mask;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		logic               last;
	} pixel_t;

	// one output transfer, pixel result or frame summary
	typedef struct {
		logic        summ;
		logic        pv;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [31:0] err;
		logic [24:0] cnt;
		logic [31:0] mn;
		logic [31:0] mx;
		logic [31:0] mean;
		logic [31:0] rmse;
		logic        lst;
	} outcome_t;

	localparam longint unsigned SqSumMax = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int unsigned RUN_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 700;
	localparam int LONG_HOLD = 3000;

	// predicts reprojected points and frame statistics, keeps expected transfers in order
	class reproj_scoreboard;
		longint offx, offy, gain, woff;
		longint unsigned focal, width;
		longint unsigned cnt, rmin, rmax, esum, sqsum;
		outcome_t awaited[$];
		int errors;

		function void clear_frame();
			cnt = 0; rmin = 64'hFFFF_FFFF; rmax = 0; esum = 0; sqsum = 0;
		endfunction

		function void power_up();
			offx = 0; offy = 0; focal = 0; gain = 0; woff = 0; width = 4096;
			errors = 0;
			clear_frame();
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] d);
			unique case (idx)
				drs_pkg::REG_OFFSET_X: offx = longint'($signed(d[16:0]));
				drs_pkg::REG_OFFSET_Y: offy = longint'($signed(d[16:0]));
				drs_pkg::REG_FOCAL:    focal = d[19:0];
				drs_pkg::REG_W_GAIN:   gain = longint'($signed(d));
				drs_pkg::REG_W_OFFSET: woff = longint'($signed(d));
				drs_pkg::REG_WIDTH:    width = d[12:0];
				default: ;
			endcase
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned r, c;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (c * c <= v)
					r = c;
			end
			return r;
		endfunction

		function logic [31:0] clip32(longint v);
			if (v > 64'sd2147483647)
				return 32'h7FFF_FFFF;
			if (v < -64'sd2147483648)
				return 32'h8000_0000;
			return v[31:0];
		endfunction

		function longint unsigned distance(longint t, longint q);
			longint d;
			d = t - q;
			return d < 0 ? longint'(-d) : d;
		endfunction

		function void stats_into(ref outcome_t o);
			o.cnt = cnt[24:0];
			o.mn = cnt != 0 ? rmin[31:0] : 32'd0;
			o.mx = cnt != 0 ? rmax[31:0] : 32'd0;
		endfunction

		function void note_pixel(pixel_t p);
			outcome_t o, s;
			longint bound, shifted, wq, nx, ny, qx, qy, qz;
			longint unsigned ax, ay, az, sa, sb, e, sq;
			logic ok, over;
			o = '{default: 0};
			bound = width > drs_pkg::MaxWidthDef ? drs_pkg::MaxWidthDef : width;
			shifted = longint'(p.col) * 16 + longint'(p.disp);
			wq = gain * longint'(p.disp) + woff * 16;
			ok = p.mask && p.row < drs_pkg::MaxHeightDef && shifted >= 0
				&& shifted < bound * 16 && wq != 0;
			if (ok) begin
				nx = longint'(p.row) * 16 + offx;
				ny = longint'(p.col) * 16 + offy;
				qx = (nx * 64'sd4294967296) / wq;
				qy = (ny * 64'sd4294967296) / wq;
				qz = (longint'(focal) * 64'sd4294967296) / wq;
				ax = distance(p.tx, qx);
				ay = distance(p.ty, qy);
				az = distance(p.tz, qz);
				if (ax >= 64'hFFFF_FFFF || ay >= 64'hFFFF_FFFF || az >= 64'hFFFF_FFFF) begin
					e = 64'hFFFF_FFFF;
				end else begin
					sa = ax * ax;
					sb = ay * ay;
					over = (sa + sb < sa);
					sa = sa + sb;
					sb = az * az;
					if (sa + sb < sa)
						over = 1;
					sa = sa + sb;
					e = over ? 64'hFFFF_FFFF : root(sa);
				end
				// accumulate unless the count has topped out
				if (cnt < drs_pkg::CountMax) begin
					sq = e * e;
					cnt++;
					if (e < rmin) rmin = e;
					if (e > rmax) rmax = e;
					esum = (drs_pkg::SumMax - esum < e) ? drs_pkg::SumMax : esum + e;
					sqsum = (sqsum + sq < sqsum) ? SqSumMax : sqsum + sq;
				end
				o.pv = 1;
				o.px = clip32(qx);
				o.py = clip32(qy);
				o.pz = clip32(qz);
				o.err = e[31:0];
			end
			stats_into(o);
			o.lst = !p.last;
			awaited = {awaited, o};
			if (p.last) begin
				s = '{default: 0};
				s.summ = 1;
				stats_into(s);
				if (cnt != 0) begin
					s.mean = 32'(esum / cnt);
					s.rmse = 32'(root(sqsum / cnt));
				end
				s.lst = 1;
				awaited = {awaited, s};
				clear_frame();
			end
		endfunction

		function void cmp(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(outcome_t g);
			outcome_t w;
			if (awaited.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
				return;
			end
			w = awaited.pop_front();
			cmp("is_summary", w.summ, g.summ);
			cmp("point_valid", w.pv, g.pv);
			cmp("point_x", w.px, g.px);
			cmp("point_y", w.py, g.py);
			cmp("point_z", w.pz, g.pz);
			cmp("error_distance", w.err, g.err);
			cmp("point_count", w.cnt, g.cnt);
			cmp("error_min", w.mn, g.mn);
			cmp("error_max", w.mx, g.mx);
			cmp("error_mean", w.mean, g.mean);
			cmp("error_rmse", w.rmse, g.rmse);
			cmp("last_result", w.lst, g.lst);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [11:0]        row_index;
	logic [11:0]        col_index;
	logic signed [15:0] disparity;
	logic               mask_valid;
	logic signed [31:0] truth_x;
	logic signed [31:0] truth_y;
	logic signed [31:0] truth_z;
	logic               last_pixel;
	logic               out_valid;
	logic               out_ready;
	logic               is_summary;
	logic               point_valid;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [31:0]        error_distance;
	logic [24:0]        point_count;
	logic [31:0]        error_min;
	logic [31:0]        error_max;
	logic [31:0]        error_mean;
	logic [31:0]        error_rmse;
	logic               last_result;

	reproj_scoreboard sb;
	int unsigned cycles = 0;
	bit no_idle;     // phase with back-to-back transfers on both sides
	bit hold_req;    // asks the receiver for one long stall

	disparity_reprojection_error_stats_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.row_index(row_index), .col_index(col_index), .disparity(disparity),
		.mask_valid(mask_valid), .truth_x(truth_x), .truth_y(truth_y), .truth_z(truth_z),
		.last_pixel(last_pixel),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_summary(is_summary), .point_valid(point_valid),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.error_distance(error_distance), .point_count(point_count),
		.error_min(error_min), .error_max(error_max),
		.error_mean(error_mean), .error_rmse(error_rmse), .last_result(last_result)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// one register transfer on the config channel, valid is dropped by the caller
	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	task automatic write_all(logic [31:0] ox, logic [31:0] oy, logic [31:0] fl,
			logic [31:0] g, logic [31:0] wo, logic [31:0] wd);
		write_reg(drs_pkg::REG_OFFSET_X, ox);
		write_reg(drs_pkg::REG_OFFSET_Y, oy);
		write_reg(drs_pkg::REG_FOCAL, fl);
		write_reg(drs_pkg::REG_W_GAIN, g);
		write_reg(drs_pkg::REG_W_OFFSET, wo);
		write_reg(drs_pkg::REG_WIDTH, wd);
		cfg_valid <= 1'b0;
	endtask

	// offer one pixel after a drawn gap, hold it until the transfer
	task automatic send_pixel(pixel_t p);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_index <= p.row;
		col_index <= p.col;
		disparity <= p.disp;
		mask_valid <= p.mask;
		truth_x <= p.tx;
		truth_y <= p.ty;
		truth_z <= p.tz;
		last_pixel <= p.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_pixel(p);
	endtask

	// block is quiet once nothing is owed and the back end had time to settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic pixel_t make_pixel(logic [11:0] r, logic [11:0] c, int d, logic m,
			int x, int y, int z, logic l);
		pixel_t p;
		p.row = r; p.col = c; p.disp = d[15:0]; p.mask = m;
		p.tx = x; p.ty = y; p.tz = z; p.last = l;
		return p;
	endfunction

	// mostly in-range shifted columns and modest truth, with some raw noise
	function automatic pixel_t rand_pixel();
		pixel_t p;
		int bound, sh, d;
		bound = sb.width > drs_pkg::MaxWidthDef ? drs_pkg::MaxWidthDef : int'(sb.width);
		p.row = 12'($urandom_range(0, 4095));
		p.col = 12'(bound > 0 ? $urandom_range(0, bound - 1) : $urandom_range(0, 4095));
		d = $urandom;
		if (bound > 0 && $urandom_range(0, 9) < 8) begin
			sh = $urandom_range(0, bound * 16 - 1);
			d = sh - int'(p.col) * 16;
			if (d > 32767 || d < -32768)
				d = $urandom;
		end
		p.disp = d[15:0];
		p.mask = $urandom_range(0, 9) != 0;
		if ($urandom_range(0, 3) == 0) begin
			p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
		end else begin
			p.tx = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
			p.ty = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
			p.tz = $urandom_range(0, 1 << 26);
		end
		p.last = $urandom_range(0, 24) == 0;
		return p;
	endfunction

	// result side: drawn stalls, one long hold on request
	initial begin
		int stall;
		outcome_t g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (hold_req) begin
				stall = LONG_HOLD;
				hold_req = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			g.summ = is_summary; g.pv = point_valid;
			g.px = point_x; g.py = point_y; g.pz = point_z;
			g.err = error_distance; g.cnt = point_count;
			g.mn = error_min; g.mx = error_max;
			g.mean = error_mean; g.rmse = error_rmse; g.lst = last_result;
			sb.check_result(g);
		end
	end

	initial begin
		pixel_t p;
		int n;
		sb = new;
		sb.power_up();
		no_idle = 0;
		hold_req = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0;
		row_index = '0; col_index = '0; disparity = '0; mask_valid = 1'b0;
		truth_x = '0; truth_y = '0; truth_z = '0; last_pixel = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings give zero W, so every pixel is unused
		send_pixel(make_pixel(12'd10, 12'd20, 32, 1, 0, 0, 0, 1));
		wait_quiet();

		// directed: sane camera, 640 wide
		write_all(-32'sd1600, -32'sd800, 32'd16000, 32'h0100_0000, 32'd0, 32'd640);
		send_pixel(make_pixel(12'd100, 12'd200, 320, 1, 0, 0, 0, 0));
		send_pixel(make_pixel(12'd5, 12'd7, 100, 0, 0, 0, 0, 0));                // mask clear
		send_pixel(make_pixel(12'd0, 12'd0, -1, 1, 0, 0, 0, 0));                 // left of image
		send_pixel(make_pixel(12'd1, 12'd639, 16, 1, 0, 0, 0, 0));               // right edge out
		send_pixel(make_pixel(12'd1, 12'd639, 15, 1, 0, 0, 0, 0));               // right edge in
		send_pixel(make_pixel(12'd3, 12'd300, 0, 1, 0, 0, 0, 0));                // zero W
		send_pixel(make_pixel(12'd4095, 12'd4095, -32768, 1, 0, 0, 0, 0));
		send_pixel(make_pixel(12'd0, 12'd0, 32767, 1, 0, 0, 0, 0));
		send_pixel(make_pixel(12'd4095, 12'd0, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 0));
		send_pixel(make_pixel(12'd50, 12'd60, 2, 1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 0));
		send_pixel(make_pixel(12'd2, 12'd2, 3, 1, 32'h8000_0000, 32'h8000_0000, 0, 1));
		send_pixel(make_pixel(12'd0, 12'd0, 0, 0, 0, 0, 0, 1));                  // empty frame
		send_pixel(make_pixel(12'd300, 12'd400, -64, 1, -1000, 2000, 3000, 0));
		send_pixel(make_pixel(12'd300, 12'd400, -64, 1, 1000, -2000, -3000, 1));
		wait_quiet();

		// random phases, extremes first, zero width third
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: write_all(32'h0000_FFFF, 32'h0000_FFFF, 32'h000F_FFFF, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h1FFF);
				1: write_all(32'hFFFF_0000, 32'hFFFF_0000, 32'd0, 32'h8000_0000,
					32'h7FFF_FFFF, 32'd1);
				2: write_all($urandom, $urandom, $urandom, $urandom, $urandom, 32'd0);
				default: write_all($urandom, $urandom, $urandom,
					($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1 << 20, 1 << 26),
					($urandom_range(0, 2) == 0) ? $urandom : 32'd0,
					$urandom_range(1, 4096));
			endcase
			no_idle = (ph % 3 == 1);
			if (ph == 4)
				hold_req = 1;
			n = (ph == 2) ? 60 : 170;
			for (int i = 0; i < n; i++) begin
				p = rand_pixel();
				send_pixel(p);
			end
			wait_quiet();
		end

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
rtl/drs_pkg.sv
rtl/drs_front.sv
rtl/drs_queue.sv
rtl/drs_divider.sv
rtl/drs_sqrt.sv
rtl/drs_back.sv
rtl/disparity_reprojection_error_stats_core.sv
verif/disparity_reprojection_error_stats_core_test.sv
